// ===== design/ift_pkg.sv =====
// Shared types and constants for the input field tokenizer.
`default_nettype none
package ift_pkg;

  // Largest field length the limit register may select
  localparam int unsigned MaxField = 1024;
  localparam int unsigned LenW     = 11;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned QueueDepth = 2;

  // Character codes
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChQuote = 8'd34;
  localparam logic [7:0] ChComma = 8'd44;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_TOKEN_LEN = 1'b0,
    REG_STRING_MODE   = 1'b1
  } ift_reg_e;

  // Byte class assigned by the front end
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_BLANK,
    CLS_LF,
    CLS_CR,
    CLS_QUOTE,
    CLS_COMMA,
    CLS_EOI
  } ift_cls_e;

  // Scan phase of the back end
  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_FIELD = 2'd1,
    PH_CR    = 2'd2,
    PH_TRAIL = 2'd3
  } ift_phase_e;

  // What a byte does to the open field
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_KEEP,
    ACT_FINISH,
    ACT_OPEN_QUOTE,
    ACT_CLOSE_QUOTE
  } ift_act_e;

  // One classified word in the queue
  typedef struct packed {
    logic [7:0] data;
    ift_cls_e   cls;
  } ift_word_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic      valid;
    ift_word_t word;
  } ift_qout_t;

endpackage
`default_nettype wire

// ===== design/ift_in_if.sv =====
// Input byte channel.
`default_nettype none
interface ift_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink (input valid, data_byte, end_of_input, output ready);
endinterface
`default_nettype wire

// ===== design/ift_out_if.sv =====
// Output field character channel.
`default_nettype none
interface ift_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       field_end;

  modport source (output valid, out_char, char_valid, field_end, input ready);
  modport sink (input valid, out_char, char_valid, field_end, output ready);
endinterface
`default_nettype wire

// ===== design/input_field_tokenizer_unit.sv =====
// Top level of the input field tokenizer.
//
//  Channel   Dir  Handshake       Word
//  in_i      in   valid/ready     data_byte[7:0], end_of_input
//  out_o     out  valid/ready     out_char[7:0], char_valid, field_end
//  cfg       in   cfg_we_i only   cfg_idx_i[0], cfg_data_i[10:0]
//
// One byte per cycle sustained while out_o is not stalled; an accepted byte
// is stored in the queue, scanned when it reaches the queue head, and its
// result is registered and offered on out_o. The two-entry queue decouples
// input from the scanner; in_i.ready drops only when the queue is full, as
// happens once out_o stalls under a steady input stream.
// Reset clears the scanner to blank skipping, limit 1024, numeric rules.
`default_nettype none
module input_field_tokenizer_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ift_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ift_pkg::CfgDataW-1:0] cfg_data_i,
  ift_in_if.sink                            in_i,
  ift_out_if.source                         out_o
);
  import ift_pkg::*;

  logic      q_full;
  logic      push;
  ift_word_t push_word;
  logic      pop;
  ift_qout_t head;

  ift_front u_front (
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_word_o (push_word)
  );

  ift_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head)
  );

  ift_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

// ===== design/ift_front.sv =====
// Front end: accepts input words and classifies each byte.
`default_nettype none
module ift_front (
  ift_in_if.sink          in_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output ift_pkg::ift_word_t push_word_o
);
  import ift_pkg::*;

  assign in_i.ready = ~q_full_i;
  assign push_o     = in_i.valid & ~q_full_i;

  // Byte class; end of input overrides the byte
  always_comb begin
    push_word_o.data = in_i.data_byte;
    if (in_i.end_of_input) begin
      push_word_o.cls = CLS_EOI;
    end else if (in_i.data_byte == ChSpace || in_i.data_byte == ChTab) begin
      push_word_o.cls = CLS_BLANK;
    end else if (in_i.data_byte == ChLf) begin
      push_word_o.cls = CLS_LF;
    end else if (in_i.data_byte == ChCr) begin
      push_word_o.cls = CLS_CR;
    end else if (in_i.data_byte == ChQuote) begin
      push_word_o.cls = CLS_QUOTE;
    end else if (in_i.data_byte == ChComma) begin
      push_word_o.cls = CLS_COMMA;
    end else begin
      push_word_o.cls = CLS_OTHER;
    end
  end

endmodule
`default_nettype wire

// ===== design/ift_queue.sv =====
// Short queue of classified words between front and back ends.
`default_nettype none
module ift_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ift_pkg::ift_word_t push_word_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output ift_pkg::ift_qout_t      head_o
);
  import ift_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ift_word_t           mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_pop;

  assign full_o      = (cnt_q == CntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.word  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i & head_o.valid;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/ift_back.sv =====
// Back end: field scanner state, config registers and output register.
`default_nettype none
module ift_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ift_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ift_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire ift_pkg::ift_qout_t           head_i,
  output logic                              pop_o,
  ift_out_if.source                         out_o
);
  import ift_pkg::*;

  logic [LenW-1:0] limit_q, limit_d;
  logic            str_mode_q, str_mode_d;

  ift_phase_e      phase_q, phase_d;
  logic            quote_q, quote_d;
  logic [LenW-1:0] len_q, len_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_char_q, out_char_d;
  logic            char_valid_q, char_valid_d;
  logic            field_end_q, field_end_d;

  ift_word_t       w;
  logic            eoi;
  logic            pre_drop;
  ift_phase_e      pre_phase;
  ift_phase_e      eff_phase;
  ift_act_e        act;
  ift_phase_e      fin_phase;
  logic [LenW-1:0] keep_len;
  logic            cut;

  logic            res_valid;
  logic [7:0]      res_char;
  logic            res_char_valid;
  logic            res_end;

  assign w     = head_i.word;
  assign eoi   = (w.cls == CLS_EOI);
  assign pop_o = head_i.valid & (~out_valid_q | out_o.ready);

  // Config writes; the length limit is clamped on write
  always_comb begin
    limit_d    = limit_q;
    str_mode_d = str_mode_q;
    if (cfg_we_i) begin
      unique case (ift_reg_e'(cfg_idx_i))
        REG_MAX_TOKEN_LEN: begin
          if (cfg_data_i == '0) begin
            limit_d = LenW'(1);
          end else if (cfg_data_i > CfgDataW'(MaxField)) begin
            limit_d = LenW'(MaxField);
          end else begin
            limit_d = LenW'(cfg_data_i);
          end
        end
        REG_STRING_MODE: str_mode_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Leading phases: after-CR, after-closing-quote and blank skipping
  always_comb begin
    pre_drop  = 1'b0;
    pre_phase = phase_q;
    eff_phase = phase_q;
    unique case (phase_q)
      PH_CR: begin
        if (w.cls == CLS_LF) begin
          pre_drop  = 1'b1;
          pre_phase = PH_SKIP;
        end else begin
          eff_phase = PH_SKIP;
        end
      end
      PH_TRAIL: begin
        priority case (w.cls)
          CLS_BLANK: begin
            pre_drop  = 1'b1;
            pre_phase = PH_TRAIL;
          end
          CLS_COMMA: begin
            pre_drop  = 1'b1;
            pre_phase = PH_SKIP;
          end
          CLS_CR: begin
            pre_drop  = 1'b1;
            pre_phase = PH_CR;
          end
          default: eff_phase = PH_SKIP;
        endcase
      end
      default: ;
    endcase
    if (!pre_drop && eff_phase == PH_SKIP) begin
      if (w.cls == CLS_BLANK || w.cls == CLS_LF || w.cls == CLS_CR) begin
        pre_drop  = 1'b1;
        pre_phase = PH_SKIP;
      end
    end
  end

  // A fresh field starts with no quote and zero length
  logic            eff_quote;
  logic [LenW-1:0] eff_len;
  assign eff_quote = (eff_phase == PH_FIELD) ? quote_q : 1'b0;
  assign eff_len   = (eff_phase == PH_FIELD) ? len_q : '0;
  assign keep_len  = eff_len + LenW'(1);
  assign cut       = (keep_len >= limit_q);

  // Field rule per byte class
  always_comb begin
    act       = ACT_NONE;
    fin_phase = PH_SKIP;
    unique case (w.cls)
      CLS_LF: act = ACT_FINISH;
      CLS_CR: begin
        act       = ACT_FINISH;
        fin_phase = PH_CR;
      end
      CLS_QUOTE: begin
        if (!eff_quote) begin
          act = (eff_len == '0) ? ACT_OPEN_QUOTE : ACT_KEEP;
        end else if (str_mode_q) begin
          act       = ACT_FINISH;
          fin_phase = PH_TRAIL;
        end else begin
          act = ACT_CLOSE_QUOTE;
        end
      end
      CLS_COMMA: act = eff_quote ? ACT_KEEP : ACT_FINISH;
      CLS_BLANK: begin
        if (eff_len == '0) begin
          act = (str_mode_q && eff_quote) ? ACT_KEEP : ACT_NONE;
        end else begin
          act = (!str_mode_q && !eff_quote) ? ACT_FINISH : ACT_KEEP;
        end
      end
      CLS_OTHER: act = ACT_KEEP;
      CLS_EOI:   act = ACT_NONE;
      default:   act = ACT_NONE;
    endcase
  end

  // Next scanner state
  always_comb begin
    phase_d = phase_q;
    quote_d = quote_q;
    len_d   = len_q;
    if (pop_o) begin
      if (eoi) begin
        phase_d = PH_SKIP;
        quote_d = 1'b0;
        len_d   = '0;
      end else if (pre_drop) begin
        phase_d = pre_phase;
      end else begin
        unique case (act)
          ACT_NONE: begin
            phase_d = PH_FIELD;
            quote_d = eff_quote;
            len_d   = eff_len;
          end
          ACT_OPEN_QUOTE: begin
            phase_d = PH_FIELD;
            quote_d = 1'b1;
            len_d   = eff_len;
          end
          ACT_CLOSE_QUOTE: begin
            phase_d = PH_FIELD;
            quote_d = 1'b0;
            len_d   = eff_len;
          end
          ACT_KEEP: begin
            phase_d = cut ? PH_SKIP : PH_FIELD;
            quote_d = cut ? 1'b0 : eff_quote;
            len_d   = cut ? '0 : keep_len;
          end
          ACT_FINISH: begin
            phase_d = fin_phase;
            quote_d = 1'b0;
            len_d   = '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result of the current word
  always_comb begin
    res_valid      = 1'b0;
    res_char       = 8'd0;
    res_char_valid = 1'b0;
    res_end        = 1'b0;
    if (eoi) begin
      res_valid = (phase_q == PH_FIELD);
      res_end   = 1'b1;
    end else if (!pre_drop) begin
      if (act == ACT_KEEP) begin
        res_valid      = 1'b1;
        res_char       = w.data;
        res_char_valid = 1'b1;
        res_end        = cut;
      end else if (act == ACT_FINISH) begin
        res_valid = 1'b1;
        res_end   = 1'b1;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_char_d   = out_char_q;
    char_valid_d = char_valid_q;
    field_end_d  = field_end_q;
    if (pop_o) begin
      out_valid_d  = res_valid;
      out_char_d   = res_char;
      char_valid_d = res_char_valid;
      field_end_d  = res_end;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LenW'(MaxField);
      str_mode_q  <= 1'b0;
      phase_q     <= PH_SKIP;
      quote_q     <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      str_mode_q  <= str_mode_d;
      phase_q     <= phase_d;
      quote_q     <= quote_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q   <= out_char_d;
    char_valid_q <= char_valid_d;
    field_end_q  <= field_end_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_char   = out_char_q;
  assign out_o.char_valid = char_valid_q;
  assign out_o.field_end  = field_end_q;

endmodule
`default_nettype wire

// ===== design/ift_checker.sv =====
// Port-level checks for the tokenizer top level, with their bind.
`default_nettype none
module ift_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       char_valid,
  input wire logic       field_end
);

  // Stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("ift: result dropped while stalled");

  // A result without a character must close a field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !char_valid |-> field_end)
    else $error("ift: empty result without field end");

  // No character carried means the character is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !char_valid |-> out_char == 8'd0)
    else $error("ift: stray character on field end");

  // Nothing is offered while reset is held
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("ift: output valid during reset");

endmodule

bind input_field_tokenizer_unit ift_checker u_ift_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_char   (out_o.out_char),
  .char_valid (out_o.char_valid),
  .field_end  (out_o.field_end)
);
`default_nettype wire
